[rtl/ief_pkg.sv]
// ief_pkg: shared types and constants for the icmp echo frame filter
// used by every module of the filter; depends on nothing
`timescale 1ns / 1ps

package ief_pkg;

    localparam logic [15:0] MAC_HDR_LEN    = 16'd14;
    localparam logic [15:0] OFF_TOTAL_HI   = 16'd16;
    localparam logic [15:0] OFF_TOTAL_LO   = 16'd17;
    localparam logic [15:0] OFF_PROTOCOL   = 16'd23;
    localparam logic [15:0] OFF_SRC_FIRST  = 16'd26;
    localparam logic [15:0] OFF_SRC_LAST   = 16'd29;
    localparam logic [15:0] OFF_MAX        = 16'hffff;
    localparam logic [15:0] MIN_FRAME_LEN  = 16'd34;
    localparam logic [15:0] ICMP_HDR_LEN   = 16'd8;
    localparam logic [15:0] MATCH_ID_RESET = 16'ha387;
    localparam logic [3:0]  MIN_HDR_WORDS  = 4'd5;
    localparam logic [3:0]  HDR_WORDS_MASK = 4'hf;
    localparam logic [7:0]  PROTO_ICMP     = 8'd1;
    localparam logic [7:0]  TYPE_REPLY     = 8'd0;
    localparam logic [7:0]  TYPE_REQUEST   = 8'd8;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic [15:0] frame_len;
        logic        first;
        logic        last;
    } item_t;

    typedef struct packed {
        logic [7:0]  payload_byte;
        logic        byte_valid;
        logic        is_reply;
        logic [31:0] source_addr;
        logic [15:0] payload_len;
        logic        end_of_payload;
    } result_t;

endpackage

[rtl/ief_in_reg.sv]
// ief_in_reg: input register stage holding one frame word
// depends on ief_pkg
`timescale 1ns / 1ps

module ief_in_reg
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  ief_pkg::item_t in_item,
    input  logic           advance,
    output logic           item_valid,
    output ief_pkg::item_t item
);

    logic           valid_reg;
    logic           valid_next;
    ief_pkg::item_t item_reg;
    logic           in_fire;

    assign in_stall = valid_reg && !advance;
    assign in_fire  = in_valid && !in_stall;

    always_comb
    begin
        if (in_fire)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

[rtl/ief_parser.sv]
// ief_parser: frame header parsing, echo match decision and payload tagging
// holds the per-frame state and the match id register; depends on ief_pkg
`timescale 1ns / 1ps

module ief_parser
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [15:0]      cfg_data,
    input  logic             fire,
    input  ief_pkg::item_t   item,
    output logic             res_valid,
    output ief_pkg::result_t res
);

    logic [15:0] match_id_reg;
    logic [15:0] offset_reg,   offset_next;
    logic [3:0]  hdr_words_reg, hdr_words_next;
    logic [15:0] total_len_reg, total_len_next;
    logic [7:0]  protocol_reg, protocol_next;
    logic [31:0] src_addr_reg, src_addr_next;
    logic [7:0]  kind_reg,     kind_next;
    logic [15:0] ident_reg,    ident_next;
    logic        dropped_reg,  dropped_next;
    logic [15:0] left_reg,     left_next;

    logic [15:0] off;
    logic [3:0]  cur_words;
    logic [15:0] cur_total;
    logic [7:0]  cur_protocol;
    logic [31:0] cur_src;
    logic [7:0]  cur_kind;
    logic [15:0] cur_ident;
    logic        cur_dropped;
    logic [15:0] cur_left;
    logic [15:0] icmp_start;
    logic [15:0] hdr_bytes;
    logic [15:0] data_len;
    logic [16:0] need_len;
    logic [15:0] left_dec;
    logic        accept_ok;

    always_comb
    begin
        off          = item.first ? '0 : offset_reg;
        cur_words    = item.first ? '0 : hdr_words_reg;
        cur_total    = item.first ? '0 : total_len_reg;
        cur_protocol = item.first ? '0 : protocol_reg;
        cur_src      = item.first ? '0 : src_addr_reg;
        cur_kind     = item.first ? '0 : kind_reg;
        cur_ident    = item.first ? '0 : ident_reg;
        cur_dropped  = item.first ? 1'b0 : dropped_reg;
        cur_left     = item.first ? '0 : left_reg;

        offset_next    = (off != ief_pkg::OFF_MAX) ? off + 16'd1 : off;
        hdr_words_next = cur_words;
        total_len_next = cur_total;
        protocol_next  = cur_protocol;
        src_addr_next  = cur_src;
        kind_next      = cur_kind;
        ident_next     = cur_ident;
        dropped_next   = cur_dropped;
        left_next      = cur_left;

        res_valid = 1'b0;
        res       = '0;

        hdr_bytes  = {10'd0, hdr_words_next, 2'b00};
        icmp_start = ief_pkg::MAC_HDR_LEN + hdr_bytes;
        data_len   = cur_total - hdr_bytes - ief_pkg::ICMP_HDR_LEN;
        need_len   = {1'b0, ief_pkg::MAC_HDR_LEN} + {1'b0, cur_total};
        left_dec   = cur_left - 16'd1;
        accept_ok  = 1'b0;

        if (!cur_dropped)
        begin
            case (off)
                ief_pkg::MAC_HDR_LEN:
                begin
                    hdr_words_next = item.data_byte[3:0] & ief_pkg::HDR_WORDS_MASK;
                    if (hdr_words_next < ief_pkg::MIN_HDR_WORDS)
                    begin
                        dropped_next = 1'b1;
                    end
                end
                ief_pkg::OFF_TOTAL_HI:
                begin
                    total_len_next = {item.data_byte, 8'd0};
                end
                ief_pkg::OFF_TOTAL_LO:
                begin
                    total_len_next = {cur_total[15:8], item.data_byte};
                end
                ief_pkg::OFF_PROTOCOL:
                begin
                    protocol_next = item.data_byte;
                end
                default:
                begin
                    if (off inside {[ief_pkg::OFF_SRC_FIRST:ief_pkg::OFF_SRC_LAST]})
                    begin
                        src_addr_next = {cur_src[23:0], item.data_byte};
                    end
                end
            endcase

            hdr_bytes  = {10'd0, hdr_words_next, 2'b00};
            icmp_start = ief_pkg::MAC_HDR_LEN + hdr_bytes;
            data_len   = total_len_next - hdr_bytes - ief_pkg::ICMP_HDR_LEN;

            if (!dropped_next && off > ief_pkg::MAC_HDR_LEN)
            begin
                if (off == icmp_start)
                begin
                    kind_next = item.data_byte;
                end
                else if (off == icmp_start + 16'd4)
                begin
                    ident_next = {item.data_byte, 8'd0};
                end
                else if (off == icmp_start + 16'd5)
                begin
                    ident_next = {cur_ident[15:8], item.data_byte};
                end
                else if (off == icmp_start + ief_pkg::ICMP_HDR_LEN - 16'd1)
                begin
                    accept_ok = (item.frame_len >= ief_pkg::MIN_FRAME_LEN)
                        && (cur_protocol == ief_pkg::PROTO_ICMP)
                        && (cur_kind == ief_pkg::TYPE_REPLY || cur_kind == ief_pkg::TYPE_REQUEST)
                        && (cur_ident == match_id_reg)
                        && (cur_total >= hdr_bytes + ief_pkg::ICMP_HDR_LEN)
                        && ({1'b0, item.frame_len} >= need_len);
                    if (!accept_ok)
                    begin
                        dropped_next = 1'b1;
                    end
                    else
                    begin
                        left_next = data_len;
                        if (data_len == 16'd0)
                        begin
                            res_valid          = 1'b1;
                            res.is_reply       = (cur_kind == ief_pkg::TYPE_REPLY);
                            res.source_addr    = cur_src;
                            res.end_of_payload = 1'b1;
                            dropped_next       = 1'b1;
                        end
                    end
                end
                else if (off > icmp_start + ief_pkg::ICMP_HDR_LEN - 16'd1
                         && cur_left != 16'd0)
                begin
                    left_next          = left_dec;
                    res_valid          = 1'b1;
                    res.payload_byte   = item.data_byte;
                    res.byte_valid     = 1'b1;
                    res.is_reply       = (cur_kind == ief_pkg::TYPE_REPLY);
                    res.source_addr    = cur_src;
                    res.payload_len    = data_len;
                    res.end_of_payload = (left_dec == 16'd0) || item.last;
                    if (left_dec == 16'd0)
                    begin
                        dropped_next = 1'b1;
                    end
                end
            end
        end

        if (item.last)
        begin
            dropped_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_id_reg <= ief_pkg::MATCH_ID_RESET;
        end
        else if (cfg_we)
        begin
            match_id_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg    <= '0;
            hdr_words_reg <= '0;
            total_len_reg <= '0;
            protocol_reg  <= '0;
            src_addr_reg  <= '0;
            kind_reg      <= '0;
            ident_reg     <= '0;
            dropped_reg   <= 1'b0;
            left_reg      <= '0;
        end
        else if (fire)
        begin
            offset_reg    <= offset_next;
            hdr_words_reg <= hdr_words_next;
            total_len_reg <= total_len_next;
            protocol_reg  <= protocol_next;
            src_addr_reg  <= src_addr_next;
            kind_reg      <= kind_next;
            ident_reg     <= ident_next;
            dropped_reg   <= dropped_next;
            left_reg      <= left_next;
        end
    end

endmodule

[rtl/ief_out_reg.sv]
// ief_out_reg: result register facing the output channel
// depends on ief_pkg
`timescale 1ns / 1ps

module ief_out_reg
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    input  logic             res_valid,
    input  ief_pkg::result_t res,
    output logic             advance,
    output logic             out_valid,
    input  logic             out_stall,
    output ief_pkg::result_t out_res
);

    logic             valid_reg;
    logic             valid_next;
    ief_pkg::result_t res_reg;
    logic             load;

    assign advance = !valid_reg || !out_stall;
    assign load    = item_valid && advance && res_valid;

    always_comb
    begin
        if (advance)
        begin
            valid_next = load;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res;
        end
    end

    assign out_valid = valid_reg;
    assign out_res   = res_reg;

endmodule

[rtl/icmp_echo_frame_filter_core.sv]
// icmp_echo_frame_filter_core: top level of the icmp echo frame filter
// path: a word accepted into the input register is parsed, and any result goes to the result register
// throughput: one frame word per cycle while the output is not stalled, set by the single parse stage
// between the input register and the result register
// reset: rst_n clears both stages, the frame state, and loads match id 0xa387
// depends on ief_pkg, ief_in_reg, ief_parser, ief_out_reg
`timescale 1ns / 1ps

module icmp_echo_frame_filter_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic [15:0] frame_len,
    input  logic        first,
    input  logic        last,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  payload_byte,
    output logic        byte_valid,
    output logic        is_reply,
    output logic [31:0] source_addr,
    output logic [15:0] payload_len,
    output logic        end_of_payload
);

    ief_pkg::item_t   in_item;
    ief_pkg::item_t   item;
    ief_pkg::result_t res;
    ief_pkg::result_t out_res;
    logic             item_valid;
    logic             advance;
    logic             fire;
    logic             res_valid;

    assign in_item.data_byte = data_byte;
    assign in_item.frame_len = frame_len;
    assign in_item.first     = first;
    assign in_item.last      = last;

    assign fire = item_valid && advance;

    ief_in_reg u_in_reg
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_item    (in_item),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    ief_parser u_parser
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .fire      (fire),
        .item      (item),
        .res_valid (res_valid),
        .res       (res)
    );

    ief_out_reg u_out_reg
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .res_valid  (res_valid),
        .res        (res),
        .advance    (advance),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_res    (out_res)
    );

    assign payload_byte   = out_res.payload_byte;
    assign byte_valid     = out_res.byte_valid;
    assign is_reply       = out_res.is_reply;
    assign source_addr    = out_res.source_addr;
    assign payload_len    = out_res.payload_len;
    assign end_of_payload = out_res.end_of_payload;

    // empty-payload marker always closes the message with zero length
    a_marker_closes: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !byte_valid |-> end_of_payload && payload_len == 16'd0)
        else $error("empty marker without end or with nonzero length");

    // a data word only comes from a message with a nonempty payload
    a_data_has_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && byte_valid |-> payload_len != 16'd0)
        else $error("payload word with zero payload length");

    // a held input word stays in the stage until the result side frees up
    a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !advance |=> item_valid && $stable(item))
        else $error("input stage lost a word while stalled");

endmodule

[sim/tb.sv]
// tb: self-checking testbench for icmp_echo_frame_filter_core
// drives frames word by word, predicts accepted echo payloads, checks every result
// depends on ief_pkg and icmp_echo_frame_filter_core
`timescale 1ns / 1ps

module tb;

    localparam int IDLE_PCT        = 36;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int SETTLE_CYCLES   = 8;
    localparam int ACTUAL_LEN      = -1;
    localparam int RANDOM_WORDS    = 200;

    typedef enum int {
        BREAK_PROTOCOL,
        BREAK_TYPE,
        BREAK_HDR_WORDS,
        BREAK_TOTAL_LEN,
        BREAK_TRUNCATE,
        BREAK_FRAME_LEN
    } frame_break_t;

    logic        clk;
    logic        rst_n          = 1'b0;
    logic        cfg_we         = 1'b0;
    logic [15:0] cfg_data       = '0;
    logic        in_valid       = 1'b0;
    logic        in_stall;
    logic [7:0]  data_byte      = '0;
    logic [15:0] frame_len      = '0;
    logic        first          = 1'b0;
    logic        last           = 1'b0;
    logic        out_valid;
    logic        out_stall      = 1'b0;
    logic [7:0]  payload_byte;
    logic        byte_valid;
    logic        is_reply;
    logic [31:0] source_addr;
    logic [15:0] payload_len;
    logic        end_of_payload;

    // frame parse state of the prediction
    logic [15:0] fr_offset   = '0;
    logic [3:0]  fr_ihl      = '0;
    logic [15:0] fr_total    = '0;
    logic [7:0]  fr_proto    = '0;
    logic [31:0] fr_src      = '0;
    logic [7:0]  fr_type     = '0;
    logic [15:0] fr_ident    = '0;
    logic        fr_drop     = 1'b0;
    logic [15:0] fr_left     = '0;
    logic [15:0] exp_match_id = ief_pkg::MATCH_ID_RESET;

    ief_pkg::result_t echo_results_due[$];
    logic [7:0]       frame_bytes[$];

    bit          tx_idle_en    = 1'b1;
    bit          rx_idle_en    = 1'b1;
    int          hold_off_req  = 0;
    int          mismatches    = 0;
    int          words_in      = 0;
    int          results_checked = 0;
    int          frames_sent   = 0;
    int          quiet_cycles  = 0;

    icmp_echo_frame_filter_core i_dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .data_byte      (data_byte),
        .frame_len      (frame_len),
        .first          (first),
        .last           (last),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .payload_byte   (payload_byte),
        .byte_valid     (byte_valid),
        .is_reply       (is_reply),
        .source_addr    (source_addr),
        .payload_len    (payload_len),
        .end_of_payload (end_of_payload)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic bit predict_echo_word(input ief_pkg::item_t w,
                                             output ief_pkg::result_t r);
        int off;
        int icmp_at;
        bit ok;
        bit emit;
        emit = 1'b0;
        r = '0;
        if (w.first)
        begin
            fr_offset = '0;
            fr_ihl    = '0;
            fr_total  = '0;
            fr_proto  = '0;
            fr_src    = '0;
            fr_type   = '0;
            fr_ident  = '0;
            fr_drop   = 1'b0;
            fr_left   = '0;
        end
        off = int'(fr_offset);
        if (fr_offset != ief_pkg::OFF_MAX)
            fr_offset = fr_offset + 16'd1;
        if (!fr_drop)
        begin
            if (off == int'(ief_pkg::MAC_HDR_LEN))
            begin
                fr_ihl = w.data_byte[3:0] & ief_pkg::HDR_WORDS_MASK;
                if (fr_ihl < ief_pkg::MIN_HDR_WORDS)
                    fr_drop = 1'b1;
            end
            else if (off == int'(ief_pkg::OFF_TOTAL_HI))
                fr_total[15:8] = w.data_byte;
            else if (off == int'(ief_pkg::OFF_TOTAL_LO))
                fr_total[7:0] = w.data_byte;
            else if (off == int'(ief_pkg::OFF_PROTOCOL))
                fr_proto = w.data_byte;
            else if (off >= int'(ief_pkg::OFF_SRC_FIRST) && off <= int'(ief_pkg::OFF_SRC_LAST))
                fr_src = {fr_src[23:0], w.data_byte};

            icmp_at = int'(ief_pkg::MAC_HDR_LEN) + 4 * int'(fr_ihl);
            if (!fr_drop && off > int'(ief_pkg::MAC_HDR_LEN))
            begin
                if (off == icmp_at)
                    fr_type = w.data_byte;
                else if (off == icmp_at + 4)
                    fr_ident[15:8] = w.data_byte;
                else if (off == icmp_at + 5)
                    fr_ident[7:0] = w.data_byte;
                else if (off == icmp_at + int'(ief_pkg::ICMP_HDR_LEN) - 1)
                begin
                    ok = w.frame_len >= ief_pkg::MIN_FRAME_LEN
                        && fr_proto == ief_pkg::PROTO_ICMP
                        && (fr_type == ief_pkg::TYPE_REPLY || fr_type == ief_pkg::TYPE_REQUEST)
                        && fr_ident == exp_match_id
                        && int'(fr_total) >= 4 * int'(fr_ihl) + int'(ief_pkg::ICMP_HDR_LEN)
                        && int'(w.frame_len) >= int'(ief_pkg::MAC_HDR_LEN) + int'(fr_total);
                    if (!ok)
                        fr_drop = 1'b1;
                    else
                    begin
                        fr_left = fr_total - {10'd0, fr_ihl, 2'b00} - ief_pkg::ICMP_HDR_LEN;
                        if (fr_left == 16'd0)
                        begin
                            r.is_reply       = (fr_type == ief_pkg::TYPE_REPLY);
                            r.source_addr    = fr_src;
                            r.end_of_payload = 1'b1;
                            emit             = 1'b1;
                            fr_drop          = 1'b1;
                        end
                    end
                end
                else if (off > icmp_at + int'(ief_pkg::ICMP_HDR_LEN) - 1 && fr_left != 16'd0)
                begin
                    fr_left          = fr_left - 16'd1;
                    r.payload_byte   = w.data_byte;
                    r.byte_valid     = 1'b1;
                    r.is_reply       = (fr_type == ief_pkg::TYPE_REPLY);
                    r.source_addr    = fr_src;
                    r.payload_len    = fr_total - {10'd0, fr_ihl, 2'b00} - ief_pkg::ICMP_HDR_LEN;
                    r.end_of_payload = (fr_left == 16'd0) || w.last;
                    emit             = 1'b1;
                    if (fr_left == 16'd0)
                        fr_drop = 1'b1;
                end
            end
        end
        if (w.last)
            fr_drop = 1'b1;
        return emit;
    endfunction

    // input side monitor: config shadow and prediction
    always @(posedge clk)
    begin : watch_input
        ief_pkg::item_t   w;
        ief_pkg::result_t r;
        if (rst_n)
        begin
            if (cfg_we)
                exp_match_id = cfg_data;
            if (in_valid && !in_stall)
            begin
                w.data_byte = data_byte;
                w.frame_len = frame_len;
                w.first     = first;
                w.last      = last;
                words_in++;
                if (predict_echo_word(w, r))
                    echo_results_due.push_back(r);
            end
        end
    end

    task automatic note_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin : check_results
        ief_pkg::result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (echo_results_due.size() == 0)
            begin
                $error("payload_byte: expected no result, got %0h", payload_byte);
                mismatches++;
            end
            else
            begin
                want = echo_results_due.pop_front();
                results_checked++;
                note_field("payload_byte", want.payload_byte, payload_byte);
                note_field("byte_valid", want.byte_valid, byte_valid);
                note_field("is_reply", want.is_reply, is_reply);
                note_field("source_addr", want.source_addr, source_addr);
                note_field("payload_len", want.payload_len, payload_len);
                note_field("end_of_payload", want.end_of_payload, end_of_payload);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
            $display("icmp_echo_frame_filter_core verification failed");
            $finish;
        end
    end

    // receiver: random stall plus an occasional long hold-off
    initial
    begin : receiver
        int hold_left;
        int req_seen;
        hold_left = 0;
        req_seen  = 0;
        forever
        begin
            @(posedge clk);
            if (hold_off_req != req_seen)
            begin
                req_seen  = hold_off_req;
                hold_left = HOLD_OFF_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= rx_idle_en && ($urandom_range(99) < IDLE_PCT);
        end
    end

    task automatic send_word(input ief_pkg::item_t w);
        if (tx_idle_en)
        begin
            while ($urandom_range(99) < IDLE_PCT)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        end
        in_valid  <= 1'b1;
        data_byte <= w.data_byte;
        frame_len <= w.frame_len;
        first     <= w.first;
        last      <= w.last;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task automatic send_frame(input int flen, input bit mark_first, input bit mark_last);
        ief_pkg::item_t w;
        foreach (frame_bytes[i])
        begin
            w.data_byte = frame_bytes[i];
            w.frame_len = (flen == ACTUAL_LEN) ? 16'(frame_bytes.size()) : 16'(flen);
            w.first     = mark_first && (i == 0);
            w.last      = mark_last && (i == frame_bytes.size() - 1);
            send_word(w);
        end
        frames_sent++;
    endtask

    task automatic build_echo(input int ihl, input int plen, input logic [7:0] kind,
                              input logic [15:0] ident, input int pad);
        logic [15:0] total;
        total = 16'(ihl * 4 + 8 + plen);
        frame_bytes.delete();
        repeat (12) frame_bytes.push_back(8'($urandom));
        frame_bytes.push_back(8'h08);
        frame_bytes.push_back(8'h00);
        frame_bytes.push_back({4'h4, 4'(ihl)});
        frame_bytes.push_back(8'($urandom));
        frame_bytes.push_back(total[15:8]);
        frame_bytes.push_back(total[7:0]);
        repeat (5) frame_bytes.push_back(8'($urandom));
        frame_bytes.push_back(ief_pkg::PROTO_ICMP);
        repeat (10) frame_bytes.push_back(8'($urandom));
        repeat ((ihl - 5) * 4) frame_bytes.push_back(8'($urandom));
        frame_bytes.push_back(kind);
        repeat (3) frame_bytes.push_back(8'($urandom));
        frame_bytes.push_back(ident[15:8]);
        frame_bytes.push_back(ident[7:0]);
        repeat (2) frame_bytes.push_back(8'($urandom));
        repeat (plen + pad) frame_bytes.push_back(8'($urandom));
    endtask

    task automatic cut_frame(input int keep);
        while (frame_bytes.size() > keep)
            void'(frame_bytes.pop_back());
    endtask

    task automatic wait_quiet();
        in_valid <= 1'b0;
        @(posedge clk);
        while (echo_results_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_match_id(input logic [15:0] id);
        cfg_we   <= 1'b1;
        cfg_data <= id;
        @(posedge clk);
        cfg_we   <= 1'b0;
        @(posedge clk);
    endtask

    task automatic test_basic_echo();
        build_echo(5, 6, ief_pkg::TYPE_REQUEST, ief_pkg::MATCH_ID_RESET, 0);
        frame_bytes[42] = 8'h00;
        frame_bytes[43] = 8'hff;
        for (int i = 26; i < 30; i++) frame_bytes[i] = 8'hff;
        send_frame(ACTUAL_LEN, 1, 1);
        build_echo(5, 3, ief_pkg::TYPE_REPLY, ief_pkg::MATCH_ID_RESET, 0);
        for (int i = 26; i < 30; i++) frame_bytes[i] = 8'h00;
        send_frame(ACTUAL_LEN, 1, 1);
        build_echo(5, 1, ief_pkg::TYPE_REPLY, ief_pkg::MATCH_ID_RESET, 0);
        send_frame(ACTUAL_LEN, 1, 1);
        wait_quiet();
    endtask

    task automatic test_empty_payload();
        build_echo(5, 0, ief_pkg::TYPE_REQUEST, ief_pkg::MATCH_ID_RESET, 0);
        send_frame(ACTUAL_LEN, 1, 1);
        build_echo(7, 0, ief_pkg::TYPE_REPLY, ief_pkg::MATCH_ID_RESET, 4);
        send_frame(ACTUAL_LEN, 1, 1);
        wait_quiet();
    endtask

    task automatic test_header_words();
        build_echo(5, 4, ief_pkg::TYPE_REQUEST, ief_pkg::MATCH_ID_RESET, 0);
        frame_bytes[14] = 8'h40;
        send_frame(ACTUAL_LEN, 1, 1);
        build_echo(5, 4, ief_pkg::TYPE_REQUEST, ief_pkg::MATCH_ID_RESET, 0);
        frame_bytes[14] = 8'h44;
        send_frame(ACTUAL_LEN, 1, 1);
        build_echo(15, 5, ief_pkg::TYPE_REPLY, ief_pkg::MATCH_ID_RESET, 0);
        send_frame(ACTUAL_LEN, 1, 1);
        build_echo(6, 2, ief_pkg::TYPE_REQUEST, ief_pkg::MATCH_ID_RESET, 0);
        frame_bytes[14] = 8'hf6;
        send_frame(ACTUAL_LEN, 1, 1);
        wait_quiet();
    endtask

    task automatic test_field_rejects();
        build_echo(5, 4, ief_pkg::TYPE_REQUEST, ief_pkg::MATCH_ID_RESET, 0);
        frame_bytes[23] = 8'd6;
        send_frame(ACTUAL_LEN, 1, 1);
        build_echo(5, 4, 8'd3, ief_pkg::MATCH_ID_RESET, 0);
        send_frame(ACTUAL_LEN, 1, 1);
        build_echo(5, 4, ief_pkg::TYPE_REQUEST, ~ief_pkg::MATCH_ID_RESET, 0);
        send_frame(ACTUAL_LEN, 1, 1);
        // frame length field below the ethernet plus ip minimum
        build_echo(5, 0, ief_pkg::TYPE_REQUEST, ief_pkg::MATCH_ID_RESET, 0);
        send_frame(33, 1, 1);
        // ip total length shorter than ip plus icmp headers
        build_echo(5, 4, ief_pkg::TYPE_REQUEST, ief_pkg::MATCH_ID_RESET, 0);
        frame_bytes[16] = 8'h00;
        frame_bytes[17] = 8'd27;
        send_frame(ACTUAL_LEN, 1, 1);
        // frame length field shorter than what the ip header claims
        build_echo(5, 4, ief_pkg::TYPE_REQUEST, ief_pkg::MATCH_ID_RESET, 0);
        send_frame(frame_bytes.size() - 1, 1, 1);
        wait_quiet();
    endtask

    task automatic test_framing();
        // frame ends inside the payload
        build_echo(5, 10, ief_pkg::TYPE_REQUEST, ief_pkg::MATCH_ID_RESET, 0);
        cut_frame(frame_bytes.size() - 4);
        send_frame(frame_bytes.size() + 4, 1, 1);
        // frame ends inside the icmp header
        build_echo(5, 6, ief_pkg::TYPE_REQUEST, ief_pkg::MATCH_ID_RESET, 0);
        cut_frame(38);
        send_frame(48, 1, 1);
        // trailing padding
        build_echo(5, 5, ief_pkg::TYPE_REPLY, ief_pkg::MATCH_ID_RESET, 12);
        send_frame(ACTUAL_LEN, 1, 1);
        // stray words between frames
        frame_bytes.delete();
        repeat (6) frame_bytes.push_back(8'($urandom));
        send_frame(ACTUAL_LEN, 0, 0);
        // new frame starts while the previous one is still open
        build_echo(5, 10, ief_pkg::TYPE_REQUEST, ief_pkg::MATCH_ID_RESET, 0);
        cut_frame(46);
        send_frame(ACTUAL_LEN, 1, 0);
        build_echo(5, 3, ief_pkg::TYPE_REQUEST, ief_pkg::MATCH_ID_RESET, 0);
        send_frame(ACTUAL_LEN, 1, 1);
        build_echo(5, 2, ief_pkg::TYPE_REPLY, ief_pkg::MATCH_ID_RESET, 0);
        send_frame(16'hffff, 1, 1);
        build_echo(5, 2, ief_pkg::TYPE_REPLY, ief_pkg::MATCH_ID_RESET, 0);
        send_frame(0, 1, 1);
        wait_quiet();
    endtask

    task automatic test_match_id();
        write_match_id(16'h0000);
        build_echo(5, 3, ief_pkg::TYPE_REQUEST, 16'h0000, 0);
        send_frame(ACTUAL_LEN, 1, 1);
        build_echo(5, 3, ief_pkg::TYPE_REQUEST, ief_pkg::MATCH_ID_RESET, 0);
        send_frame(ACTUAL_LEN, 1, 1);
        wait_quiet();
        write_match_id(16'hffff);
        build_echo(5, 3, ief_pkg::TYPE_REPLY, 16'hffff, 0);
        send_frame(ACTUAL_LEN, 1, 1);
        build_echo(5, 3, ief_pkg::TYPE_REPLY, 16'h0000, 0);
        send_frame(ACTUAL_LEN, 1, 1);
        wait_quiet();
        write_match_id(ief_pkg::MATCH_ID_RESET);
    endtask

    task automatic test_backpressure();
        hold_off_req <= hold_off_req + 1;
        build_echo(5, 40, ief_pkg::TYPE_REQUEST, ief_pkg::MATCH_ID_RESET, 0);
        send_frame(ACTUAL_LEN, 1, 1);
        wait_quiet();
    endtask

    task automatic test_long_frame();
        // long accepted payload and padding with neither side idling
        tx_idle_en = 1'b0;
        rx_idle_en <= 1'b0;
        build_echo(5, 120, ief_pkg::TYPE_REPLY, ief_pkg::MATCH_ID_RESET, 20);
        send_frame(16'hffff, 1, 1);
        wait_quiet();
        tx_idle_en = 1'b1;
        rx_idle_en <= 1'b1;
    endtask

    task automatic test_random_traffic();
        logic [15:0] ids[4];
        logic [15:0] ident;
        int          sent_before;
        int          icmp_at;
        int          roll;
        ids[0] = 16'h0000;
        ids[1] = 16'hffff;
        ids[2] = 16'($urandom);
        ids[3] = ief_pkg::MATCH_ID_RESET;
        for (int p = 0; p < 4; p++)
        begin
            write_match_id(ids[p]);
            sent_before = words_in;
            while (words_in - sent_before < RANDOM_WORDS / 4)
            begin
                roll  = $urandom_range(99);
                ident = ($urandom_range(99) < 85) ? ids[p] : 16'($urandom);
                if (roll < 95)
                begin
                    build_echo(($urandom_range(9) == 0) ? $urandom_range(6, 15) : 5,
                               ($urandom_range(7) == 0) ? 0 : $urandom_range(1, 24),
                               $urandom_range(1) ? ief_pkg::TYPE_REPLY
                                                 : ief_pkg::TYPE_REQUEST,
                               ident, ($urandom_range(2) == 0) ? $urandom_range(1, 6) : 0);
                    icmp_at = 14 + 4 * int'(frame_bytes[14][3:0]);
                    if (roll < 70)
                        send_frame(($urandom_range(5) == 0)
                                   ? $urandom_range(frame_bytes.size(), 65535)
                                   : ACTUAL_LEN, 1, 1);
                    else
                    begin
                        case (frame_break_t'($urandom_range(5)))
                            BREAK_PROTOCOL:  frame_bytes[23] = 8'($urandom_range(2, 255));
                            BREAK_TYPE:      frame_bytes[icmp_at] = 8'($urandom);
                            BREAK_HDR_WORDS: frame_bytes[14] = {4'h4, 4'($urandom_range(4))};
                            BREAK_TOTAL_LEN:
                            begin
                                frame_bytes[16] = 8'($urandom_range(1));
                                frame_bytes[17] = 8'($urandom);
                            end
                            BREAK_TRUNCATE:  cut_frame($urandom_range(1, frame_bytes.size() - 1));
                            default:         ;
                        endcase
                        send_frame(($urandom_range(3) == 0) ? $urandom_range(65535)
                                   : ACTUAL_LEN, 1, $urandom_range(3) != 0);
                    end
                end
                else
                begin
                    frame_bytes.delete();
                    repeat ($urandom_range(1, 40)) frame_bytes.push_back(8'($urandom));
                    send_frame($urandom_range(65535), 1'($urandom_range(1)), 1);
                end
            end
            wait_quiet();
        end
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_basic_echo();
        test_empty_payload();
        test_header_words();
        test_field_rejects();
        test_framing();
        test_match_id();
        test_backpressure();
        test_long_frame();
        test_random_traffic();
        wait_quiet();
        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("summary: %0d frames, %0d words in, %0d results checked, %0d mismatches",
                 frames_sent, words_in, results_checked, mismatches);
        $display("covered header rejects, early ends, padding, id settings and back pressure");
        if (mismatches == 0 && echo_results_due.size() == 0)
            $display("icmp_echo_frame_filter_core verification clean");
        else
            $display("icmp_echo_frame_filter_core verification failed");
        $finish;
    end

endmodule
